[sv/assert_macros.svh]
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check a property on every rising clock edge outside reset
`define CHK_CLK(label, clk_s, rst_n, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (prop)) else $error(msg);
// check an implication whose consequent must hold in the next cycle
`define CHK_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[sv/ffca_pkg.sv]
// shared types and constants of the free-region allocator
package ffca_pkg;
	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;
	localparam logic [31:0] HDR_BYTES = 32'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARD,
		ST_ACHK,
		ST_RRD,
		ST_RCHK,
		ST_DECIDE,
		ST_RDEC,
		ST_SHL_RD,
		ST_SHL_WR,
		ST_SHR_RD,
		ST_SHR_WR,
		ST_WRITE,
		ST_DONE
	} ffca_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_inc;
		logic rd_scan;
		logic rd_prev;
		logic cap_hit;
		logic cap_prev;
		logic decide;
		logic shl_rd;
		logic shl_wr;
		logic shr_rd;
		logic shr_wr;
		logic wr_final;
		logic finish;
	} ffca_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_release;
		logic hdr_ovf;
		logic scan_end;
		logic fit;
		logic above;
		logic need_shl;
		logic need_shr;
		logic shl_end;
		logic shr_end;
	} ffca_sts_t;
endpackage

[sv/ffca_if.sv]
// valid/ready channel carrying one beat of payload
interface ffca_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/ffca_ram.sv]
// generic single-port-write ram with registered read
module ffca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/ffca_ctrl.sv]
// controller state machine of the allocator
module ffca_ctrl import ffca_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ffca_sts_t sts,
	output ffca_cmd_t cmd
);
	ffca_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_ARD: state_d = ST_ACHK;
			ST_ACHK: begin
				if (sts.fit) state_d = sts.need_shl ? ST_SHL_RD : ST_WRITE;
				else if (sts.scan_end) state_d = ST_DONE;
				else state_d = ST_ARD;
			end
			ST_RRD: state_d = ST_RCHK;
			ST_RCHK: begin
				if (sts.above || sts.scan_end) state_d = ST_RDEC;
				else state_d = ST_RRD;
			end
			ST_DECIDE: begin
				if (sts.is_release) begin
					state_d = sts.scan_end ? ST_RDEC : ST_RRD;
				end else begin
					state_d = (sts.hdr_ovf || sts.scan_end) ? ST_DONE : ST_ARD;
				end
			end
			ST_RDEC: state_d = ST_SHR_RD;
			ST_SHL_RD: state_d = sts.shl_end ? ST_WRITE : ST_SHL_WR;
			ST_SHL_WR: state_d = ST_SHL_RD;
			ST_SHR_RD: begin
				if (sts.need_shl) state_d = ST_SHL_RD;
				else if (!sts.need_shr || sts.shr_end) state_d = ST_WRITE;
				else state_d = ST_SHR_WR;
			end
			ST_SHR_WR: state_d = ST_SHR_RD;
			ST_WRITE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DECIDE: cmd.scan_clr = 1'b1;
			ST_ARD: cmd.rd_scan = 1'b1;
			ST_ACHK: begin
				cmd.cap_hit = 1'b1;
				cmd.scan_inc = !sts.fit;
			end
			ST_RRD: cmd.rd_scan = 1'b1;
			ST_RCHK: begin
				cmd.cap_prev = 1'b1;
				cmd.scan_inc = !sts.above;
			end
			ST_RDEC: cmd.decide = 1'b1;
			ST_SHL_RD: cmd.shl_rd = 1'b1;
			ST_SHL_WR: cmd.shl_wr = 1'b1;
			ST_SHR_RD: cmd.shr_rd = 1'b1;
			ST_SHR_WR: cmd.shr_wr = 1'b1;
			ST_WRITE: cmd.wr_final = 1'b1;
			ST_DONE: begin
				out_valid = 1'b1;
				cmd.finish = out_ready;
			end
			default: ;
		endcase
		cmd.rd_prev = 1'b0;
	end
endmodule

[sv/ffca_dp.sv]
// datapath: region table, scan index, counters and result register
module ffca_dp import ffca_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ffca_cmd_t   cmd,
	output ffca_sts_t   sts,
	input  logic        in_func,
	input  logic [31:0] in_addr,
	input  logic [31:0] in_size,
	output logic        ok,
	output logic [31:0] result_addr,
	output logic [$clog2(TABLE_ENTRIES+1)-1:0] entries_in_use,
	output logic [$clog2(TABLE_ENTRIES+1)-1:0] peak_entries,
	output logic [32:0] total_free,
	output logic [31:0] lost_count,
	output logic [31:0] lost_bytes
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES+1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	logic        func_q;
	logic [31:0] addr_q, size_q;
	logic [CW-1:0] idx_q, cnt_q, peak_q, sh_q;
	logic [32:0] total_q;
	logic [31:0] lcnt_q, lbytes_q;
	logic        ok_q;
	logic [31:0] res_q;
	// previous and next entry seen by the release scan
	logic [31:0] ps_q, pl_q;
	logic        has_prev_q, has_next_q;
	logic [31:0] ns_q, nl_q;
	// final write
	logic [31:0] ws_q, wl_q;
	logic [AW-1:0] wa_q;
	logic        wen_q;
	logic        remove_q, insert_q, drop_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wsd, wld, rs, rl;
	logic [32:0]   need;
	logic [31:0]   need32;

	assign need   = {1'b0, size_q} + 33'(HDR_BYTES);
	assign need32 = need[31:0];

	ffca_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_start (
		.clk, .we, .waddr, .wdata(wsd), .raddr, .rdata(rs));
	ffca_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_len (
		.clk, .we, .waddr, .wdata(wld), .raddr, .rdata(rl));

	// release merge decision, taken when the scan ends
	logic [31:0] rend, pend;
	logic        m_prev, m_next;
	assign rend   = addr_q + size_q;
	assign pend   = ps_q + pl_q;
	assign m_prev = has_prev_q && pend == addr_q;
	assign m_next = has_next_q && rend == ns_q;

	// read address and shift write
	always_comb begin
		raddr = idx_q[AW-1:0];
		if (cmd.shl_rd) raddr = AW'(sh_q + CW'(1));
		if (cmd.shr_rd) raddr = AW'(sh_q - CW'(1));
		we = 1'b0;
		waddr = sh_q[AW-1:0];
		wsd = rs;
		wld = rl;
		if (cmd.shl_wr || cmd.shr_wr) we = 1'b1;
		if (cmd.wr_final) begin
			we = wen_q;
			waddr = wa_q;
			wsd = ws_q;
			wld = wl_q;
		end
	end

	// status
	always_comb begin
		sts = '0;
		sts.is_release = func_q == FUNC_RELEASE;
		sts.hdr_ovf = need[32];
		sts.scan_end = (idx_q + CW'(1)) >= cnt_q || cnt_q == '0;
		if (cmd.scan_clr) sts.scan_end = cnt_q == '0;
		sts.fit = rl >= need32;
		sts.above = rs > addr_q;
		sts.need_shl = remove_q || (func_q == FUNC_ALLOC && rl == need32);
		sts.need_shr = insert_q;
		sts.shl_end = sh_q >= cnt_q;
		sts.shr_end = sh_q <= idx_q;
	end

	// sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			peak_q <= '0;
			total_q <= '0;
			lcnt_q <= '0;
			lbytes_q <= '0;
			idx_q <= '0;
			sh_q <= '0;
			func_q <= FUNC_ALLOC;
			ok_q <= 1'b0;
			res_q <= '0;
			wen_q <= 1'b0;
			remove_q <= 1'b0;
			insert_q <= 1'b0;
			drop_q <= 1'b0;
			has_prev_q <= 1'b0;
			has_next_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				func_q <= in_func;
				addr_q <= in_addr;
				size_q <= in_size;
				ok_q <= 1'b0;
				res_q <= '0;
				wen_q <= 1'b0;
				remove_q <= 1'b0;
				insert_q <= 1'b0;
				drop_q <= 1'b0;
				has_prev_q <= 1'b0;
				has_next_q <= 1'b0;
			end
			if (cmd.scan_clr) idx_q <= '0;
			if (cmd.scan_inc) idx_q <= idx_q + CW'(1);
			// allocate hit
			if (cmd.cap_hit && sts.fit) begin
				ok_q <= 1'b1;
				res_q <= rs + HDR_BYTES;
				total_q <= total_q - need;
				wen_q <= rl != need32;
				remove_q <= rl == need32;
				wa_q <= idx_q[AW-1:0];
				ws_q <= rs + need32;
				wl_q <= rl - need32;
				sh_q <= idx_q;
				if (rl == need32) cnt_q <= cnt_q - CW'(1);
			end
			// release scan
			if (cmd.cap_prev) begin
				if (sts.above) begin
					has_next_q <= 1'b1;
					ns_q <= rs;
					nl_q <= rl;
				end else begin
					has_prev_q <= 1'b1;
					ps_q <= rs;
					pl_q <= rl;
					if (sts.scan_end) idx_q <= idx_q + CW'(1);
				end
			end
			// release decision, taken in the cycle after the scan
			if (cmd.decide && func_q == FUNC_RELEASE && !remove_q && !insert_q &&
					!drop_q && !wen_q && !ok_q) begin
				ok_q <= 1'b1;
				if (m_prev) begin
					wen_q <= 1'b1;
					wa_q <= AW'(idx_q - CW'(1));
					ws_q <= ps_q;
					if (m_next) begin
						wl_q <= pl_q + size_q + nl_q;
						total_q <= total_q + {1'b0, pl_q + size_q + nl_q}
							- {1'b0, pl_q} - {1'b0, nl_q};
						remove_q <= 1'b1;
						sh_q <= idx_q;
						cnt_q <= cnt_q - CW'(1);
					end else begin
						wl_q <= pl_q + size_q;
						total_q <= total_q + {1'b0, pl_q + size_q} - {1'b0, pl_q};
					end
				end else if (m_next) begin
					wen_q <= 1'b1;
					wa_q <= idx_q[AW-1:0];
					ws_q <= addr_q;
					wl_q <= nl_q + size_q;
					total_q <= total_q + {1'b0, nl_q + size_q} - {1'b0, nl_q};
				end else if (cnt_q < FULL) begin
					wen_q <= 1'b1;
					insert_q <= 1'b1;
					wa_q <= idx_q[AW-1:0];
					ws_q <= addr_q;
					wl_q <= size_q;
					total_q <= total_q + {1'b0, size_q};
					sh_q <= cnt_q;
					cnt_q <= cnt_q + CW'(1);
					if (peak_q < cnt_q + CW'(1)) peak_q <= cnt_q + CW'(1);
				end else begin
					ok_q <= 1'b0;
					drop_q <= 1'b1;
					lcnt_q <= lcnt_q + 32'd1;
					lbytes_q <= lbytes_q + size_q;
				end
			end
			// shift steps
			if (cmd.shl_wr) sh_q <= sh_q + CW'(1);
			if (cmd.shr_wr) sh_q <= sh_q - CW'(1);
		end
	end

	// merge-with-both shifts entries down from idx; the decide cycle preloads sh_q
	// shift left reads sh+1 and writes sh; the counter already dropped by one

	assign ok = ok_q;
	assign result_addr = res_q;
	assign entries_in_use = cnt_q;
	assign peak_entries = peak_q;
	assign total_free = total_q;
	assign lost_count = lcnt_q;
	assign lost_bytes = lbytes_q;
endmodule

[sv/first_fit_coalescing_allocator.sv]
// First-fit free-region allocator with coalescing. The table of free
// regions sits in two rams of TABLE_ENTRIES words with registered read.
// One request at a time: an allocate scans the table, with a read and a
// check step per entry, until the first fit; a release scans until the
// first region above its address and then decides; removing or inserting
// an entry moves every entry behind it with a read and a write step per
// entry. The result beat is held until taken. No clearing pass.
module first_fit_coalescing_allocator import ffca_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	ffca_if.sink   req,
	ffca_if.source rsp
);
	ffca_cmd_t cmd;
	ffca_sts_t sts;

	// controller
	ffca_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts, .cmd);

	// datapath
	ffca_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_func(req.data.func), .in_addr(req.data.addr), .in_size(req.data.size),
		.ok(rsp.data.ok), .result_addr(rsp.data.result_addr),
		.entries_in_use(rsp.data.entries_in_use), .peak_entries(rsp.data.peak_entries),
		.total_free(rsp.data.total_free), .lost_count(rsp.data.lost_count),
		.lost_bytes(rsp.data.lost_bytes));
endmodule

[sv/ffca_checker.sv]
// port-level checker for the allocator, bound to the top level
`include "assert_macros.svh"
module ffca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        ok,
	input logic [31:0] result_addr,
	input logic [6:0]  entries_in_use,
	input logic [6:0]  peak_entries
);
	`CHK_CLK(a_peak, clk, arst_n, peak_entries >= entries_in_use, "peak below count")
	`CHK_CLK(a_excl, clk, arst_n, !(in_ready && out_valid), "accept while result pending")
	`CHK_NEXT(a_stall, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`CHK_CLK(a_fail0, clk, arst_n, !out_valid || ok || result_addr == 32'd0, "fail not zero")
endmodule

bind first_fit_coalescing_allocator ffca_checker u_chk (
	.clk, .arst_n,
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.ok(rsp.data.ok), .result_addr(rsp.data.result_addr),
	.entries_in_use(rsp.data.entries_in_use), .peak_entries(rsp.data.peak_entries));
